@@ src/gec_pkg.sv @@
// Shared types for the greedy element colouring block.
// Holds the controller state enum and the command/status structs; no dependencies.
`timescale 1ns / 1ps

package gec_pkg;

  localparam int unsigned VertW    = 12;
  localparam int unsigned ColorW   = 6;
  localparam int unsigned UsedW    = 7;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned FieldCnt = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_SEARCH,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            load;
    logic            clr;
    logic            rd_en;
    logic            wr_en;
    logic            search;
    logic            out_load;
    logic [CfgW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic out_busy;
  } status_t;

endpackage

@@ src/gec_ctrl.sv @@
// Controller for the greedy element colouring block: sequences the clearing pass,
// the mask reads, the colour search, the write-back and the result hand-off. Uses gec_pkg.
`timescale 1ns / 1ps

module gec_ctrl #(
  parameter int unsigned MAX_ELEM_VERTS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [gec_pkg::CfgW-1:0] cfg_data,
  input  gec_pkg::status_t       status,
  output gec_pkg::cmd_t          cmd
);
  import gec_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [CfgW-1:0] cnt;
  logic [CfgW-1:0] cnt_next;
  logic [CfgW-1:0] verts_cfg;
  logic [CfgW-1:0] n_act;
  logic [CfgW-1:0] n_last;

  // Saturate the register to the number of vertex fields in use
  always_comb begin
    n_act = verts_cfg;
    if (32'(verts_cfg) > MAX_ELEM_VERTS) n_act = CfgW'(MAX_ELEM_VERTS);
    if (32'(n_act) > FieldCnt) n_act = CfgW'(FieldCnt);
    n_last = n_act - CfgW'(1);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      verts_cfg <= CfgW'(4);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_valid && cfg_ready) verts_cfg <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = (n_act == '0) ? ST_SEARCH : ST_READ;
      end
      ST_READ: begin
        cnt_next = cnt + CfgW'(1);
        if (cnt == n_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cnt_next   = '0;
        state_next = (status.found && n_act != '0) ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        cnt_next = cnt + CfgW'(1);
        if (cnt == n_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.idx = cnt;
    unique case (state)
      ST_CLEAR:  cmd.clr      = 1'b1;
      ST_IDLE:   cmd.load     = in_valid;
      ST_READ:   cmd.rd_en    = 1'b1;
      ST_DRAIN:  cmd.rd_en    = 1'b0;
      ST_SEARCH: cmd.search   = 1'b1;
      ST_WRITE:  cmd.wr_en    = 1'b1;
      ST_DONE:   cmd.out_load = !status.out_busy;
      default:   cmd.clr      = 1'b0;
    endcase
  end

endmodule

@@ src/gec_dp.sv @@
// Datapath for the greedy element colouring block: vertex mask memory, held masks,
// lowest-free-colour search and the result register. Uses gec_pkg, driven by gec_ctrl.
`timescale 1ns / 1ps

module gec_dp #(
  parameter int unsigned NUM_VERTS      = 4096,
  parameter int unsigned MAX_COLORS     = 64,
  parameter int unsigned MAX_ELEM_VERTS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gec_pkg::cmd_t              cmd,
  output gec_pkg::status_t           status,
  input  logic [gec_pkg::VertW-1:0]  vert_a,
  input  logic [gec_pkg::VertW-1:0]  vert_b,
  input  logic [gec_pkg::VertW-1:0]  vert_c,
  input  logic [gec_pkg::VertW-1:0]  vert_d,
  input  logic [gec_pkg::VertW-1:0]  vert_e,
  input  logic [gec_pkg::VertW-1:0]  vert_f,
  input  logic [gec_pkg::VertW-1:0]  vert_g,
  input  logic [gec_pkg::VertW-1:0]  vert_h,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gec_pkg::ColorW-1:0] elem_color,
  output logic                       no_color,
  output logic [gec_pkg::UsedW-1:0]  colors_used
);
  import gec_pkg::*;

  localparam int unsigned AW = (NUM_VERTS > 1) ? $clog2(NUM_VERTS) : 1;
  localparam int unsigned IW = (MAX_ELEM_VERTS > 1) ? $clog2(MAX_ELEM_VERTS) : 1;

  logic [MAX_COLORS-1:0] mem [NUM_VERTS];
  logic [MAX_COLORS-1:0] rd_data;
  logic [MAX_COLORS-1:0] held [MAX_ELEM_VERTS];
  logic [MAX_COLORS-1:0] taken;
  logic [MAX_COLORS-1:0] wr_data;
  logic [MAX_COLORS-1:0] color_bit;
  logic [VertW-1:0]      ports [FieldCnt];
  logic [VertW-1:0]      vid [MAX_ELEM_VERTS];
  logic [MAX_ELEM_VERTS-1:0] vvalid;
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         addr;
  logic                  we;
  logic                  cap_en;
  logic [IW-1:0]         cap_idx;
  logic [IW-1:0]         cur_idx;
  logic [ColorW-1:0]     color_c;
  logic                  found_c;
  logic [ColorW-1:0]     color;
  logic                  found;
  logic [UsedW-1:0]      highest;

  assign ports[0] = vert_a;
  assign ports[1] = vert_b;
  assign ports[2] = vert_c;
  assign ports[3] = vert_d;
  assign ports[4] = vert_e;
  assign ports[5] = vert_f;
  assign ports[6] = vert_g;
  assign ports[7] = vert_h;

  assign cur_idx = cmd.idx[IW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_ELEM_VERTS; i++) begin
      vvalid[i] = (32'(vid[i]) < NUM_VERTS);
    end
  end

  // Capture the element's vertex ids at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_ELEM_VERTS; i++) vid[i] <= ports[i];
    end
  end

  assign color_bit = MAX_COLORS'(1) << color;
  assign wr_data   = cmd.clr ? '0 : (held[cur_idx] | color_bit);
  assign we        = cmd.clr || (cmd.wr_en && vvalid[cur_idx]);

  always_comb begin
    priority if (cmd.clr) addr = clr_addr;
    else                  addr = AW'(vid[cur_idx]);
  end

  // Single-port mask store, read-first
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wr_data;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign status.clr_last = (clr_addr == AW'(NUM_VERTS - 1));

  // Read data lands in the cycle after the address; track which vertex it belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_en <= 1'b0;
    end else begin
      cap_en <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= cur_idx;
    if (cmd.load) begin
      taken <= '0;
    end else if (cap_en) begin
      held[cap_idx] <= rd_data;
      if (vvalid[cap_idx]) taken <= taken | rd_data;
    end
  end

  // Lowest clear bit of the OR of the masks
  always_comb begin
    color_c = '0;
    found_c = 1'b0;
    for (int c = MAX_COLORS - 1; c >= 0; c--) begin
      if (!taken[c]) begin
        color_c = ColorW'(c);
        found_c = 1'b1;
      end
    end
  end

  assign status.found = found_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
    end else if (cmd.search && found_c &&
                 ({1'b0, color_c} + UsedW'(1) > highest)) begin
      highest <= {1'b0, color_c} + UsedW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      color <= color_c;
      found <= found_c;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      elem_color  <= found ? color : '0;
      no_color    <= !found;
      colors_used <= highest;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

@@ src/greedy_element_coloring.sv @@
// Top level of the greedy element colouring block.
// Joins gec_ctrl and gec_dp; uses gec_pkg.
`timescale 1ns / 1ps

// Greedy colouring of mesh elements. Each element accepted on the input channel
// gets the lowest colour not yet held by any earlier element sharing one of its
// vertices, and the running count of colours in use comes with it. After reset
// the block sweeps the vertex mask store once with in_stall high; configuration
// writes are taken throughout. From accept to result an element then passes
// these steps, n being the active vertex count (verts_cfg saturated to
// MAX_ELEM_VERTS and FieldCnt): the single-port mask memory is read once per
// vertex, a drain state lets the last read land, a search state finds the
// colour, the masks are written back once per vertex and a done state loads the
// result. When every colour is taken the write-back is skipped, and with n zero
// only the search and the load remain. The next element can be accepted in the
// cycle after the result is loaded; in_stall stays high from accept until then,
// so elements do not overlap. The result sits in an output register, so the
// next element is accepted while it waits to be taken; that element's own
// result is held back until the output register is free.
module greedy_element_coloring #(
  parameter int unsigned NUM_VERTS      = 4096,
  parameter int unsigned MAX_COLORS     = 64,
  parameter int unsigned MAX_ELEM_VERTS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gec_pkg::CfgW-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gec_pkg::VertW-1:0]  vert_a,
  input  logic [gec_pkg::VertW-1:0]  vert_b,
  input  logic [gec_pkg::VertW-1:0]  vert_c,
  input  logic [gec_pkg::VertW-1:0]  vert_d,
  input  logic [gec_pkg::VertW-1:0]  vert_e,
  input  logic [gec_pkg::VertW-1:0]  vert_f,
  input  logic [gec_pkg::VertW-1:0]  vert_g,
  input  logic [gec_pkg::VertW-1:0]  vert_h,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gec_pkg::ColorW-1:0] elem_color,
  output logic                       no_color,
  output logic [gec_pkg::UsedW-1:0]  colors_used
);
  import gec_pkg::*;

  cmd_t    cmd;
  status_t status;

  gec_ctrl #(
    .MAX_ELEM_VERTS(MAX_ELEM_VERTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .cmd      (cmd)
  );

  gec_dp #(
    .NUM_VERTS     (NUM_VERTS),
    .MAX_COLORS    (MAX_COLORS),
    .MAX_ELEM_VERTS(MAX_ELEM_VERTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .vert_a     (vert_a),
    .vert_b     (vert_b),
    .vert_c     (vert_c),
    .vert_d     (vert_d),
    .vert_e     (vert_e),
    .vert_f     (vert_f),
    .vert_g     (vert_g),
    .vert_h     (vert_h),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .elem_color (elem_color),
    .no_color   (no_color),
    .colors_used(colors_used)
  );

endmodule
